[src/vgcd_pkg.sv]
package vgcd_pkg;

    localparam int COORD_W        = 32;
    localparam int REL_W          = COORD_W + 1;
    localparam int DIST_W         = 2 * COORD_W;
    localparam int ACC_W          = DIST_W + 2;
    localparam int DATA_W         = 3 * COORD_W;
    localparam int SHIFT_W        = 5;
    localparam int CFG_IDX_W      = 2;
    localparam int DEF_GRID_DIV   = 16;
    localparam int DEF_COORD_BITS = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Z   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CELL_SHIFT = 2'd3;

    localparam logic [SHIFT_W-1:0] CELL_SHIFT_RESET = 5'd8;
    localparam logic               FUNC_CLEAR       = 1'b1;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [REL_W-1:0]   rel_t;

    typedef struct packed {
        logic   valid;
        coord_t x;
        coord_t y;
        coord_t z;
    } cell_word_t;

    typedef struct packed {
        logic done;
        logic closer;
    } dist_stat_t;

endpackage

[src/vgcd_cell_mem.sv]
module vgcd_cell_mem import vgcd_pkg::*; #(
    parameter int DEPTH  = DEF_GRID_DIV * DEF_GRID_DIV * DEF_GRID_DIV,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  cell_word_t        wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output cell_word_t        rd_data
);

    cell_word_t cell_mem [DEPTH];
    cell_word_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            cell_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= cell_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[src/vgcd_dist.sv]
module vgcd_dist import vgcd_pkg::*; #(
    parameter  int IDX_W = $clog2(DEF_GRID_DIV),
    localparam int CEN_W = IDX_W + COORD_W
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  rel_t             rel_p [3],
    input  rel_t             rel_q [3],
    input  logic [CEN_W-1:0] cen [3],
    output dist_stat_t       stat
);

    localparam int          DW        = CEN_W + 3;
    localparam logic [2:0]  NUM_AXES  = 3'd3;
    localparam logic [2:0]  NUM_TERMS = 3'd6;

    logic [2:0]         term_reg;
    logic               busy_reg;
    logic               va_reg;
    logic               vb_reg;
    dist_stat_t         stat_reg;
    logic [COORD_W-1:0] mag_a_reg;
    logic               big_a_reg;
    logic               side_a_reg;
    logic [DIST_W-1:0]  prod_reg;
    logic               big_b_reg;
    logic               side_b_reg;
    logic [ACC_W-1:0]   acc_p_reg;
    logic [ACC_W-1:0]   acc_q_reg;
    logic               sat_p_reg;
    logic               sat_q_reg;

    logic               side;
    logic [1:0]         axis;
    rel_t               rel_sel;
    logic signed [DW-1:0] rel_ext;
    logic signed [DW-1:0] cen_ext;
    logic signed [DW-1:0] d_val;
    logic [DW-1:0]      mag_val;
    logic               big;
    logic [DIST_W-1:0]  dist_p;
    logic [DIST_W-1:0]  dist_q;

    always_comb begin
        side    = (term_reg >= NUM_AXES);
        axis    = side ? 2'(term_reg - NUM_AXES) : 2'(term_reg);
        rel_sel = side ? rel_q[axis] : rel_p[axis];
        rel_ext = DW'(rel_sel);
        cen_ext = $signed(DW'(cen[axis]));
        d_val   = (rel_ext <<< 1) - cen_ext;
        mag_val = d_val[DW-1] ? $unsigned(-d_val) : $unsigned(d_val);
        big     = |mag_val[DW-1:COORD_W];
        dist_p  = (sat_p_reg || (|acc_p_reg[ACC_W-1:DIST_W])) ? '1 : acc_p_reg[DIST_W-1:0];
        dist_q  = (sat_q_reg || (|acc_q_reg[ACC_W-1:DIST_W])) ? '1 : acc_q_reg[DIST_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            term_reg <= '0;
            va_reg   <= 1'b0;
            vb_reg   <= 1'b0;
            stat_reg <= '0;
        end else begin
            stat_reg.done <= busy_reg && !start && (term_reg == NUM_TERMS)
                             && !va_reg && !vb_reg;
            vb_reg        <= va_reg;
            va_reg        <= busy_reg && !start && (term_reg != NUM_TERMS);
            if (start) begin
                busy_reg <= 1'b1;
                term_reg <= '0;
            end else if (busy_reg) begin
                if (term_reg != NUM_TERMS) begin
                    term_reg <= term_reg + 3'd1;
                end else if (!va_reg && !vb_reg) begin
                    busy_reg        <= 1'b0;
                    stat_reg.closer <= (dist_p < dist_q);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        mag_a_reg  <= mag_val[COORD_W-1:0];
        big_a_reg  <= big;
        side_a_reg <= side;
        prod_reg   <= mag_a_reg * mag_a_reg;
        big_b_reg  <= big_a_reg;
        side_b_reg <= side_a_reg;
        if (start) begin
            acc_p_reg <= '0;
            acc_q_reg <= '0;
            sat_p_reg <= 1'b0;
            sat_q_reg <= 1'b0;
        end else if (vb_reg) begin
            if (side_b_reg) begin
                acc_q_reg <= acc_q_reg + ACC_W'(prod_reg);
                sat_q_reg <= sat_q_reg | big_b_reg;
            end else begin
                acc_p_reg <= acc_p_reg + ACC_W'(prod_reg);
                sat_p_reg <= sat_p_reg | big_b_reg;
            end
        end
    end

    assign stat = stat_reg;

endmodule

[src/voxel_grid_center_downsampler.sv]
// Channel   Dir  Handshake            Payload
// s_        in   s_tvalid/s_tready    tdata: px, py, pz; tuser: func
// m_        out  m_tvalid/m_tready    tdata: out_x, out_y, out_z; tuser: was_replaced
// cfg_      in   cfg_valid/cfg_ready  cfg_index, cfg_data
//
// A point outside the grid leaves after S_INDEX; a point into an empty cell is written
// in S_EVAL; a point into an occupied cell also waits in S_DIST while six squares go
// one at a time through a single 32x32 multiplier. A clear word sweeps the cell
// memory, one entry per cycle. After reset the same sweep runs before s_tready
// rises; configuration writes are taken throughout.
// A held result word stalls only the next point that produces a result.
module voxel_grid_center_downsampler import vgcd_pkg::*; #(
    parameter int GRID_DIV   = DEF_GRID_DIV,
    parameter int COORD_BITS = DEF_COORD_BITS
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [DATA_W-1:0]    s_tdata,    // px, py, pz
    input  logic [0:0]           s_tuser,    // func
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [DATA_W-1:0]    m_tdata,    // out_x, out_y, out_z
    output logic [0:0]           m_tuser,    // was_replaced
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [COORD_W-1:0]   cfg_data
);

    localparam int NCELLS  = GRID_DIV * GRID_DIV * GRID_DIV;
    localparam int IDX_W   = (GRID_DIV > 1) ? $clog2(GRID_DIV) : 1;
    localparam int ADDR_W  = (NCELLS > 1) ? $clog2(NCELLS) : 1;
    localparam int CEN_W   = IDX_W + COORD_W;
    localparam int EXT_W   = IDX_W + COORD_W + 1;
    localparam int SEXT_SH = COORD_W - COORD_BITS;
    localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(NCELLS - 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_INDEX,
        S_ADDR,
        S_READ,
        S_EVAL,
        S_DIST,
        S_DECIDE
    } state_t;

    function automatic coord_t sext_c(input logic [COORD_W-1:0] v);
        logic [COORD_W-1:0] t;
        t = v << SEXT_SH;
        return coord_t'($signed(t) >>> SEXT_SH);
    endfunction

    state_t              state_reg, state_next;
    logic [ADDR_W-1:0]   sweep_reg, sweep_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [DATA_W-1:0]   m_tdata_reg, m_tdata_next;
    logic [0:0]          m_tuser_reg, m_tuser_next;
    logic                dist_start_reg, dist_start_next;

    coord_t              org_reg [3];
    logic [SHIFT_W-1:0]  cell_shift_reg;

    coord_t              p_reg [3];
    rel_t                rel_p_reg [3];
    rel_t                rel_q_reg [3];
    logic [IDX_W-1:0]    idx_reg [3];
    logic [CEN_W-1:0]    cen_reg [3];
    logic [ADDR_W-1:0]   addr_reg;

    coord_t              org_s [3];
    coord_t              q_s [3];
    rel_t                rel_c [3];
    rel_t                rel_q_c [3];
    logic [IDX_W-1:0]    idx_c [3];
    logic [CEN_W-1:0]    cen_c [3];
    logic [EXT_W-1:0]    ext_c;
    logic                in_grid;
    logic [ADDR_W-1:0]   addr_c;

    logic                wr_en;
    logic [ADDR_W-1:0]   wr_addr;
    cell_word_t          wr_data;
    logic                rd_en;
    cell_word_t          rd_data;
    dist_stat_t          dist_stat;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == S_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_tuser_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            org_reg[0]     <= '0;
            org_reg[1]     <= '0;
            org_reg[2]     <= '0;
            cell_shift_reg <= CELL_SHIFT_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_ORIGIN_X:   org_reg[0]     <= cfg_data;
                CFG_ORIGIN_Y:   org_reg[1]     <= cfg_data;
                CFG_ORIGIN_Z:   org_reg[2]     <= cfg_data;
                CFG_CELL_SHIFT: cell_shift_reg <= cfg_data[SHIFT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        q_s[0] = $signed(rd_data.x);
        q_s[1] = $signed(rd_data.y);
        q_s[2] = $signed(rd_data.z);
        ext_c   = EXT_W'(GRID_DIV) << cell_shift_reg;
        in_grid = 1'b1;
        for (int a = 0; a < 3; a++) begin
            org_s[a]   = sext_c(org_reg[a]);
            rel_c[a]   = REL_W'(p_reg[a]) - REL_W'(org_s[a]);
            rel_q_c[a] = REL_W'(q_s[a]) - REL_W'(org_s[a]);
            in_grid    = in_grid && !rel_c[a][REL_W-1]
                         && (EXT_W'(rel_c[a][COORD_W-1:0]) < ext_c);
            idx_c[a]   = IDX_W'(rel_p_reg[a][COORD_W-1:0] >> cell_shift_reg);
            cen_c[a]   = CEN_W'({idx_reg[a], 1'b1}) << cell_shift_reg;
        end
        addr_c = (ADDR_W'(idx_c[0]) * ADDR_W'(GRID_DIV) + ADDR_W'(idx_c[1]))
                 * ADDR_W'(GRID_DIV) + ADDR_W'(idx_c[2]);
    end

    always_comb begin
        state_next      = state_reg;
        sweep_next      = sweep_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tdata_next    = m_tdata_reg;
        m_tuser_next    = m_tuser_reg;
        dist_start_next = 1'b0;
        wr_en           = 1'b0;
        wr_addr         = addr_reg;
        wr_data         = '{valid: 1'b1, x: p_reg[0], y: p_reg[1], z: p_reg[2]};
        rd_en           = 1'b0;
        unique case (state_reg)
            S_CLEAR: begin
                wr_en         = 1'b1;
                wr_addr       = sweep_reg;
                wr_data.valid = 1'b0;
                if (sweep_reg == LAST_CELL) begin
                    sweep_next = '0;
                    state_next = S_IDLE;
                end else begin
                    sweep_next = sweep_reg + ADDR_W'(1);
                end
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    state_next = (s_tuser[0] == FUNC_CLEAR) ? S_CLEAR : S_INDEX;
                end
            end
            S_INDEX: begin
                state_next = in_grid ? S_ADDR : S_IDLE;
            end
            S_ADDR: begin
                state_next = S_READ;
            end
            S_READ: begin
                rd_en      = 1'b1;
                state_next = S_EVAL;
            end
            S_EVAL: begin
                if (!rd_data.valid) begin
                    wr_en      = 1'b1;
                    state_next = S_IDLE;
                end else begin
                    dist_start_next = 1'b1;
                    state_next      = S_DIST;
                end
            end
            S_DIST: begin
                if (dist_stat.done) begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    state_next    = S_IDLE;
                    if (dist_stat.closer) begin
                        wr_en        = 1'b1;
                        m_tdata_next = {rd_data.z, rd_data.y, rd_data.x};
                        m_tuser_next = 1'b1;
                    end else begin
                        m_tdata_next = {p_reg[2], p_reg[1], p_reg[0]};
                        m_tuser_next = 1'b0;
                    end
                end
            end
            default: begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_CLEAR;
            sweep_reg      <= '0;
            m_tvalid_reg   <= 1'b0;
            dist_start_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            sweep_reg      <= sweep_next;
            m_tvalid_reg   <= m_tvalid_next;
            dist_start_reg <= dist_start_next;
        end
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_IDLE) begin
            p_reg[0] <= sext_c(s_tdata[COORD_W-1:0]);
            p_reg[1] <= sext_c(s_tdata[2*COORD_W-1:COORD_W]);
            p_reg[2] <= sext_c(s_tdata[3*COORD_W-1:2*COORD_W]);
        end
        if (state_reg == S_INDEX) begin
            rel_p_reg <= rel_c;
        end
        if (state_reg == S_ADDR) begin
            idx_reg  <= idx_c;
            addr_reg <= addr_c;
        end
        if (state_reg == S_READ) begin
            cen_reg <= cen_c;
        end
        if (state_reg == S_EVAL) begin
            rel_q_reg <= rel_q_c;
        end
    end

    vgcd_cell_mem #(
        .DEPTH  (NCELLS),
        .ADDR_W (ADDR_W)
    ) u_cell_mem (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (addr_reg),
        .rd_data (rd_data)
    );

    vgcd_dist #(
        .IDX_W (IDX_W)
    ) u_dist (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (dist_start_reg),
        .rel_p   (rel_p_reg),
        .rel_q   (rel_q_reg),
        .cen     (cen_reg),
        .stat    (dist_stat)
    );

endmodule

[src/vgcd_checker.sv]
module vgcd_checker import vgcd_pkg::*; (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [DATA_W-1:0]    m_tdata,
    input logic [0:0]           m_tuser
);

    // the cell sweep holds off input right after reset
    assert property (@(posedge aclk) !aresetn |=> !s_tready)
        else $error("input ready right after reset");

    // one word in flight at a time
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input ready in the cycle after an accepted word");

    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result raised while input was open");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

endmodule

bind voxel_grid_center_downsampler vgcd_checker u_checker (.*);

[tb/voxel_grid_center_downsampler_tb.sv]
`timescale 1ns / 1ps

module voxel_grid_center_downsampler_tb import vgcd_pkg::*;;

    localparam int      GRID_DIV      = DEF_GRID_DIV;
    localparam int      NUM_SLOTS     = GRID_DIV * GRID_DIV * GRID_DIV;
    localparam int      SETTLE_CYCLES = NUM_SLOTS + 64;
    localparam int      HOLD_CYCLES   = 400;
    localparam int      CYCLE_LIMIT   = 1000000;
    localparam int      POOL_SIZE     = 8;
    localparam longint COORD_MAX     = 64'sd2147483647;
    localparam longint COORD_MIN     = -64'sd2147483648;

    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t z;
        logic   replaced;
    } emit_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [DATA_W-1:0]    s_tdata   = '0;    // px, py, pz
    logic [0:0]           s_tuser   = '0;    // func
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [DATA_W-1:0]    m_tdata;           // out_x, out_y, out_z
    logic [0:0]           m_tuser;           // was_replaced
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [COORD_W-1:0]   cfg_data  = '0;

    coord_t             grid_org_x = '0;
    coord_t             grid_org_y = '0;
    coord_t             grid_org_z = '0;
    logic [SHIFT_W-1:0] grid_shift = CELL_SHIFT_RESET;
    bit                 occupied [NUM_SLOTS];
    coord_t             kept_x [NUM_SLOTS];
    coord_t             kept_y [NUM_SLOTS];
    coord_t             kept_z [NUM_SLOTS];
    emit_t              pending_emits [$];

    int pool_cell [POOL_SIZE][3];
    int mismatch_count = 0;
    int cycle_count    = 0;
    bit quiet          = 1'b0;
    bit hold_req       = 1'b0;

    voxel_grid_center_downsampler uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Squared distance to the center of a cell, in quarter units, saturating.
    function automatic logic [63:0] center_dist2(coord_t ax, coord_t ay, coord_t az,
                                                 int ix, int iy, int iz);
        longint      pt [3];
        longint      og [3];
        int          id [3];
        longint      d;
        logic [63:0] mag;
        logic [63:0] sq;
        logic [63:0] sum;
        pt[0] = ax;
        pt[1] = ay;
        pt[2] = az;
        og[0] = grid_org_x;
        og[1] = grid_org_y;
        og[2] = grid_org_z;
        id[0] = ix;
        id[1] = iy;
        id[2] = iz;
        sum = '0;
        for (int k = 0; k < 3; k++) begin
            d = 2 * (pt[k] - og[k]) - (longint'(2 * id[k] + 1) << grid_shift);
            if (d < 0) begin
                mag = -d;
            end else begin
                mag = d;
            end
            if (mag >= 64'h1_0000_0000) return '1;
            sq = mag * mag;
            if (sum > ~sq) return '1;
            sum = sum + sq;
        end
        return sum;
    endfunction

    task automatic voxel_filter_step(logic func, coord_t px, coord_t py, coord_t pz);
        longint pt [3];
        longint og [3];
        longint rel;
        longint span;
        int     id [3];
        int     slot;
        emit_t  e;
        if (func == FUNC_CLEAR) begin
            foreach (occupied[i]) occupied[i] = 1'b0;
            return;
        end
        pt[0] = px;
        pt[1] = py;
        pt[2] = pz;
        og[0] = grid_org_x;
        og[1] = grid_org_y;
        og[2] = grid_org_z;
        span = longint'(GRID_DIV) << grid_shift;
        for (int k = 0; k < 3; k++) begin
            rel = pt[k] - og[k];
            if (rel < 0 || rel >= span) return;
            id[k] = int'(rel >> grid_shift);
        end
        slot = (id[0] * GRID_DIV + id[1]) * GRID_DIV + id[2];
        if (!occupied[slot]) begin
            occupied[slot] = 1'b1;
            kept_x[slot] = px;
            kept_y[slot] = py;
            kept_z[slot] = pz;
            return;
        end
        if (center_dist2(px, py, pz, id[0], id[1], id[2]) <
            center_dist2(kept_x[slot], kept_y[slot], kept_z[slot], id[0], id[1], id[2])) begin
            e = '{kept_x[slot], kept_y[slot], kept_z[slot], 1'b1};
            kept_x[slot] = px;
            kept_y[slot] = py;
            kept_z[slot] = pz;
        end else begin
            e = '{px, py, pz, 1'b0};
        end
        pending_emits.push_back(e);
    endtask

    task automatic send_word(logic func, coord_t px, coord_t py, coord_t pz);
        while (!quiet && $urandom_range(0, 99) < 6) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= {pz, py, px};
        do @(posedge aclk); while (!s_tready);
        voxel_filter_step(func, px, py, pz);
    endtask

    task automatic send_point(coord_t px, coord_t py, coord_t pz);
        send_word(1'b0, px, py, pz);
    endtask

    task automatic send_clear();
        send_word(FUNC_CLEAR, coord_t'($urandom), coord_t'($urandom), coord_t'($urandom));
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [COORD_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_ORIGIN_X:   grid_org_x = coord_t'(value);
            CFG_ORIGIN_Y:   grid_org_y = coord_t'(value);
            CFG_ORIGIN_Z:   grid_org_z = coord_t'(value);
            CFG_CELL_SHIFT: grid_shift = value[SHIFT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_grid(coord_t ox, coord_t oy, coord_t oz, logic [SHIFT_W-1:0] shift);
        write_reg(CFG_ORIGIN_X, ox);
        write_reg(CFG_ORIGIN_Y, oy);
        write_reg(CFG_ORIGIN_Z, oz);
        write_reg(CFG_CELL_SHIFT, COORD_W'(shift));
        cfg_valid <= 1'b0;
    endtask

    // Drain all pending words, then cover a full clear sweep.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_emits.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    function automatic coord_t clamp_coord(longint v);
        if (v > COORD_MAX) v = COORD_MAX;
        if (v < COORD_MIN) v = COORD_MIN;
        return coord_t'(v);
    endfunction

    function automatic coord_t pick_axis(coord_t org, int id, bit near_center);
        longint span;
        longint off;
        span = longint'(1) << grid_shift;
        if (near_center) begin
            off = span / 2 - 2 + $urandom_range(0, 4);
            if (off < 0) off = 0;
            if (off >= span) off = span - 1;
        end else begin
            off = longint'({$urandom, $urandom}) & (span - 1);
        end
        return clamp_coord(longint'(org) + (longint'(id) << grid_shift) + off);
    endfunction

    function automatic coord_t edge_axis(coord_t org);
        longint span;
        longint rel;
        span = longint'(GRID_DIV) << grid_shift;
        case ($urandom_range(0, 3))
            0: rel = -1;
            1: rel = 0;
            2: rel = span - 1;
            default: rel = span;
        endcase
        return clamp_coord(longint'(org) + rel);
    endfunction

    task automatic send_pool_point();
        int  p;
        bit  near;
        p    = $urandom_range(0, POOL_SIZE - 1);
        near = $urandom_range(0, 1);
        send_point(pick_axis(grid_org_x, pool_cell[p][0], near),
                   pick_axis(grid_org_y, pool_cell[p][1], near),
                   pick_axis(grid_org_z, pool_cell[p][2], near));
    endtask

    task automatic send_random_item();
        int     r;
        int     p;
        coord_t c [3];
        r = $urandom_range(0, 99);
        if (r < 2) begin
            send_clear();
        end else if (r < 10) begin
            send_point(coord_t'($urandom), coord_t'($urandom), coord_t'($urandom));
        end else if (r < 18) begin
            p = $urandom_range(0, POOL_SIZE - 1);
            c[0] = $urandom_range(0, 1) ? edge_axis(grid_org_x)
                                        : pick_axis(grid_org_x, pool_cell[p][0], 1'b0);
            c[1] = $urandom_range(0, 1) ? edge_axis(grid_org_y)
                                        : pick_axis(grid_org_y, pool_cell[p][1], 1'b0);
            c[2] = $urandom_range(0, 1) ? edge_axis(grid_org_z)
                                        : pick_axis(grid_org_z, pool_cell[p][2], 1'b0);
            send_point(c[0], c[1], c[2]);
        end else begin
            send_pool_point();
        end
    endtask

    task automatic run_phase(coord_t ox, coord_t oy, coord_t oz, logic [SHIFT_W-1:0] shift,
                             bit clear_first, int count);
        settle();
        set_grid(ox, oy, oz, shift);
        if (clear_first) send_clear();
        foreach (pool_cell[i, k]) pool_cell[i][k] = $urandom_range(0, GRID_DIV - 1);
        repeat (count) send_random_item();
    endtask

    task automatic test_reset_grid_corners();
        send_point(32'sd0, 32'sd0, 32'sd0);
        send_point(32'sd128, 32'sd128, 32'sd128);
        send_point(32'sd128, 32'sd128, 32'sd128);
        send_point(32'sd4095, 32'sd4095, 32'sd4095);
        send_point(32'sd4096, 32'sd0, 32'sd0);
        send_point(32'sd0, -32'sd1, 32'sd0);
        send_point(32'sd0, 32'sd0, 32'sd4096);
        send_point(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
        send_point(32'sh80000000, 32'sh80000000, 32'sh80000000);
        send_point(32'sd4095, 32'sd4095, 32'sd4095);
        send_point(32'sd3968, 32'sd3968, 32'sd3968);
        send_point(32'sd3968, 32'sd4000, 32'sd3968);
        send_clear();
        send_point(32'sd128, 32'sd128, 32'sd128);
        send_point(32'sd0, 32'sd0, 32'sd0);
        send_point(32'sd255, 32'sd255, 32'sd255);
    endtask

    task automatic test_stale_cell_after_config();
        settle();
        set_grid(32'sh7fffffff, 32'sd0, 32'sd0, 5'd24);
        send_point(32'sh7fffffff, 32'sd0, 32'sd0);
        send_point(32'sh7fffffff, 32'sh00800000, 32'sh00800000);
        send_point(32'sh7fffffff, 32'sh00ffffff, 32'sh00ffffff);
        settle();
        set_grid(32'sh80000000, 32'sh80000000, 32'sh80000000, 5'd31);
        send_point(32'sd0, 32'sd0, 32'sd0);
        send_point(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
        send_point(32'sh40000000, 32'sh40000000, 32'sh40000000);
        send_point(32'sh80000000, 32'sh80000000, 32'sh80000000);
    endtask

    task automatic test_random_phases();
        run_phase(32'sd0, 32'sd0, 32'sd0, 5'd8, 1'b1, 130);
        run_phase(coord_t'($urandom_range(0, 255)), -coord_t'($urandom_range(0, 255)),
                  coord_t'($urandom_range(0, 255)), 5'd0, 1'b0, 130);
        quiet = 1'b1;
        run_phase(32'sh80000000, 32'sh80000000, 32'sh80000000, 5'd24, 1'b1, 120);
        quiet = 1'b0;
        run_phase(coord_t'($urandom), coord_t'($urandom), coord_t'($urandom), 5'd3, 1'b0, 130);
        run_phase(32'sh7fffffff, 32'sh80000000, 32'sd0, 5'd24, 1'b0, 100);
        run_phase(coord_t'($urandom), coord_t'($urandom), coord_t'($urandom), 5'd31, 1'b1, 80);
        repeat (2) begin
            run_phase(coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
                      SHIFT_W'($urandom_range(0, 24)), 1'b0, 100);
        end
    endtask

    task automatic test_backpressure();
        settle();
        set_grid(-32'sd1000, 32'sd500, -32'sd7, 5'd4);
        foreach (pool_cell[i, k]) pool_cell[i][k] = $urandom_range(0, 1);
        repeat (POOL_SIZE * 2) send_pool_point();
        hold_req = 1'b1;
        repeat (60) send_pool_point();
    endtask

    initial begin
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            m_tready <= quiet || ($urandom_range(0, 99) >= 6);
        end
    end

    always @(posedge aclk) begin : check_emit
        emit_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_emits.size() == 0) begin
                $display("%0t: unexpected word data=%h replaced=%b", $time, m_tdata, m_tuser);
                mismatch_count++;
            end else begin
                want = pending_emits.pop_front();
                if (m_tdata[COORD_W-1:0] !== want.x) begin
                    $display("%0t: out_x expected %h got %h", $time, want.x,
                             m_tdata[COORD_W-1:0]);
                    mismatch_count++;
                end
                if (m_tdata[2*COORD_W-1:COORD_W] !== want.y) begin
                    $display("%0t: out_y expected %h got %h", $time, want.y,
                             m_tdata[2*COORD_W-1:COORD_W]);
                    mismatch_count++;
                end
                if (m_tdata[3*COORD_W-1:2*COORD_W] !== want.z) begin
                    $display("%0t: out_z expected %h got %h", $time, want.z,
                             m_tdata[3*COORD_W-1:2*COORD_W]);
                    mismatch_count++;
                end
                if (m_tuser[0] !== want.replaced) begin
                    $display("%0t: was_replaced expected %b got %b", $time, want.replaced,
                             m_tuser[0]);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("voxel_grid_center_downsampler_tb: FAIL");
            $finish;
        end
    end

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        test_reset_grid_corners();
        test_stale_cell_after_config();
        test_random_phases();
        test_backpressure();
        settle();
        if (mismatch_count == 0 && pending_emits.size() == 0) begin
            $display("voxel_grid_center_downsampler_tb: PASS");
        end else begin
            $display("voxel_grid_center_downsampler_tb: FAIL");
        end
        $finish;
    end

endmodule

[files.f]
src/vgcd_pkg.sv
src/vgcd_cell_mem.sv
src/vgcd_dist.sv
src/voxel_grid_center_downsampler.sv
src/vgcd_checker.sv
tb/voxel_grid_center_downsampler_tb.sv
